/* rtl/core/serial_command_line_parser_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef SERIAL_COMMAND_LINE_PARSER_CORE_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SCLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sclp check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SCLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sclp check failed");

`endif

/* rtl/core/sclp_pkg.sv */
`timescale 1ns / 1ps
package sclp_pkg;

    localparam int LINE_CAPACITY = 128;
    localparam int ARG_CAPACITY  = 10;

    localparam int LINE_W    = $clog2(LINE_CAPACITY);
    localparam int ARG_IDX_W = (ARG_CAPACITY > 1) ? $clog2(ARG_CAPACITY) : 1;
    localparam int COUNT_W   = 4;
    localparam int VALUE_W   = 31;
    localparam int TDATA_W   = 40;

    localparam logic [LINE_W-1:0]  LINE_LAST = LINE_W'(LINE_CAPACITY - 1);
    localparam logic [VALUE_W-1:0] ARG_MAX   = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] CODE_ERROR = 3'd0;
    localparam logic [2:0] CODE_EMPTY = 3'd7;
    localparam logic [3:0] CODE_NONE  = 4'd8;

    // Command names, second char in the upper byte.
    // RS, DF, GV, CR, CP, L0, GB
    localparam logic [15:0] CMD_NAMES [7] = '{
        16'h5352, 16'h4644, 16'h5647, 16'h5243, 16'h5043, 16'h304C, 16'h4247
    };

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TXT_EMPTY = 3'd1,
        PH_TXT_CMD   = 3'd2,
        PH_TXT_ARGS  = 3'd3,
        PH_BIN_CMD2  = 3'd4,
        PH_BIN_COUNT = 3'd5,
        PH_BIN_ARGS  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SQ_PARSE = 2'd0,
        SQ_HEAD  = 2'd1,
        SQ_ARG   = 2'd2
    } seq_t;

    typedef struct packed {
        phase_t              phase;
        logic [LINE_W-1:0]   line_len;
        logic                token_open;
        logic [15:0]         chars;
        logic [1:0]          char_cnt;
        logic [2:0]          parsed;
        logic                line_err;
        logic                text_ended;
        logic [COUNT_W-1:0]  arg_total;
        logic [7:0]          raw_rem;
        logic [VALUE_W-1:0]  acc;
    } parse_state_t;

    function automatic logic [7:0] upcase(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // Code 0..6, or CODE_NONE.
    function automatic logic [3:0] cmd_lookup(logic [7:0] c0, logic [7:0] c1);
        logic [3:0] code;
        code = CODE_NONE;
        for (int i = 6; i >= 0; i--) begin
            if (CMD_NAMES[i] == {c1, c0}) begin
                code = 4'(i);
            end
        end
        return code;
    endfunction

endpackage

/* rtl/core/serial_command_line_parser_core.sv */
`timescale 1ns / 1ps
// Serial command-line parser.
// Slave stream (s_*) takes one received byte per transfer. Master stream (m_*)
// gives, per decoded command, one header (m_tuser = 0) and then one transfer per
// argument (m_tuser = 1); m_tlast marks the final transfer of a command.
// cfg_wen/cfg_wdata write binary_mode (0 text lines, 1 binary packets); a write
// drops any partial command. Write it only while the block is idle.
// Throughput: one byte per cycle while parsing; the per-byte parse is
// combinational. When a byte ends a command, s_tready drops and the emit
// sequencer hands out the header and then its arguments, reading the argument
// RAM once per argument (registered read, prefetched while the previous result
// goes out). m_tvalid rises with the header once the sequencer has entered its
// header state and loaded the output register.
// A stalled m_tready holds the current result in the output register; the
// sequencer waits, and s_tready stays low until the last transfer of the
// command is loaded into the output register.
// Reset (rst_n low, async): text mode, parser idle, no result pending. The
// argument RAM is not cleared; only entries written for the current command
// are read.
module serial_command_line_parser_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic                        cfg_wdata,   // binary_mode
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] status, [3:1] command_code, [7:4] arg_count, [38:8] arg_value, [39] 0
    output logic [sclp_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,     // [0] kind
    output logic                        m_tlast      // last
);
    import sclp_pkg::*;

    // configuration and parse state
    logic         binary_mode_reg;
    parse_state_t ps_reg, ps_next;

    // emit sequencer
    seq_t                 seq_reg, seq_next;
    logic [2:0]           em_code_reg, em_code_next;
    logic [COUNT_W-1:0]   em_n_reg, em_n_next;
    logic                 em_err_reg, em_err_next;
    logic [ARG_IDX_W-1:0] em_idx_reg, em_idx_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic               out_kind_reg, out_kind_next;
    logic               out_status_reg, out_status_next;
    logic [2:0]         out_code_reg, out_code_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    // argument RAM
    logic                 ram_we, ram_re;
    logic [ARG_IDX_W-1:0] ram_waddr, ram_raddr;
    logic [VALUE_W-1:0]   ram_wdata, ram_rdata;

    logic               in_xfer;
    logic               start_emit, start_err;
    logic [2:0]         start_code;
    logic [COUNT_W-1:0] start_n;

    assign s_tready = (seq_reg == SQ_PARSE);
    assign in_xfer  = s_tvalid && s_tready;

    sclp_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(ARG_CAPACITY)
    ) u_arg_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // ---------------------------------------------------------------
    // Byte parser: one byte per cycle while s_tready is high.
    // ---------------------------------------------------------------
    always_comb
    begin
        parse_state_t       cur;
        logic [7:0]         c;
        logic               body, eol, do_close, is_digit;
        logic [3:0]         code;
        logic [VALUE_W+3:0] prod;

        c          = s_tdata;
        cur        = ps_reg;
        body       = 1'b0;
        eol        = 1'b0;
        do_close   = 1'b0;
        is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
        code       = CODE_NONE;
        prod       = '0;
        start_emit = 1'b0;
        start_err  = 1'b0;
        start_code = CODE_ERROR;
        start_n    = '0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;

        // a mode change leaves the other mode's partial command behind
        if (binary_mode_reg ? (ps_reg.phase != PH_IDLE && ps_reg.phase < PH_BIN_CMD2)
                            : (ps_reg.phase >= PH_BIN_CMD2))
        begin
            cur = '0;
        end
        ps_next = cur;

        if (binary_mode_reg)
        begin
            case (cur.phase)
                PH_IDLE:
                begin
                    ps_next.chars    = {8'h00, c};
                    ps_next.char_cnt = 2'd1;
                    ps_next.phase    = PH_BIN_CMD2;
                end
                PH_BIN_CMD2:
                begin
                    code = (cur.chars[7:0] == CH_NUL) ? {1'b0, CODE_EMPTY}
                                                      : cmd_lookup(cur.chars[7:0], c);
                    ps_next.chars    = {c, cur.chars[7:0]};
                    ps_next.char_cnt = 2'd2;
                    ps_next.parsed   = code[2:0];
                    ps_next.phase    = PH_BIN_COUNT;
                    if (code[3])
                    begin
                        start_emit = 1'b1;
                        start_err  = 1'b1;
                    end
                end
                PH_BIN_COUNT:
                begin
                    if (c > 8'(ARG_CAPACITY))
                    begin
                        start_emit = 1'b1;
                        start_err  = 1'b1;
                    end
                    else if (c == CH_NUL)
                    begin
                        start_emit = 1'b1;
                        start_code = cur.parsed;
                    end
                    else
                    begin
                        ps_next.raw_rem   = c;
                        ps_next.arg_total = '0;
                        ps_next.phase     = PH_BIN_ARGS;
                    end
                end
                default:
                begin
                    if (cur.arg_total < COUNT_W'(ARG_CAPACITY))
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = cur.arg_total[ARG_IDX_W-1:0];
                        ram_wdata         = {{(VALUE_W-8){1'b0}}, upcase(c)};
                        ps_next.arg_total = cur.arg_total + 1'b1;
                    end
                    if (cur.raw_rem != 8'd0)
                    begin
                        ps_next.raw_rem = cur.raw_rem - 1'b1;
                    end
                    if (ps_next.raw_rem == 8'd0)
                    begin
                        start_emit = 1'b1;
                        start_code = cur.parsed;
                        start_n    = ps_next.arg_total;
                    end
                end
            endcase
        end
        else if (cur.line_len >= LINE_LAST)
        begin
            // overlong line: error at once
            start_emit = 1'b1;
            start_err  = 1'b1;
        end
        else
        begin
            ps_next.line_len = cur.line_len + 1'b1;
            case (cur.phase)
                PH_IDLE:
                begin
                    if (c == CH_CR)
                    begin
                        start_emit = 1'b1;
                        start_code = CODE_EMPTY;
                    end
                    else if (c == CH_LF)
                    begin
                        ps_next.phase = PH_TXT_EMPTY;
                    end
                    else
                    begin
                        ps_next.phase = PH_TXT_CMD;
                        body          = 1'b1;
                    end
                end
                PH_TXT_EMPTY:
                begin
                    if (c == CH_CR)
                    begin
                        start_emit = 1'b1;
                        start_code = CODE_EMPTY;
                    end
                end
                default:
                begin
                    if (c != CH_CR)
                    begin
                        body = 1'b1;
                    end
                    else
                    begin
                        eol      = 1'b1;
                        do_close = !cur.text_ended;
                    end
                end
            endcase

            if (body && !cur.text_ended)
            begin
                if (c == CH_NUL)
                begin
                    do_close           = 1'b1;
                    ps_next.text_ended = 1'b1;
                end
                else if (c == CH_SPACE || c == CH_LF)
                begin
                    do_close = 1'b1;
                end
                else
                begin
                    ps_next.token_open = 1'b1;
                    if (ps_next.phase == PH_TXT_CMD)
                    begin
                        if (cur.char_cnt < 2'd2)
                        begin
                            if (cur.char_cnt[0])
                            begin
                                ps_next.chars[15:8] = upcase(c);
                            end
                            else
                            begin
                                ps_next.chars[7:0] = upcase(c);
                            end
                            ps_next.char_cnt = cur.char_cnt + 1'b1;
                        end
                        else
                        begin
                            ps_next.char_cnt = 2'd3;
                        end
                    end
                    else if (is_digit)
                    begin
                        // acc * 10 + digit, saturating
                        prod = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1)
                             + (VALUE_W+4)'(c[3:0]);
                        ps_next.acc = (prod > (VALUE_W+4)'(ARG_MAX)) ? ARG_MAX
                                                                     : prod[VALUE_W-1:0];
                    end
                    else
                    begin
                        ps_next.line_err = 1'b1;
                    end
                end
            end

            if (do_close && cur.token_open)
            begin
                ps_next.token_open = 1'b0;
                if (ps_next.phase == PH_TXT_CMD)
                begin
                    if (cur.char_cnt == 2'd2)
                    begin
                        code = cmd_lookup(cur.chars[7:0], cur.chars[15:8]);
                    end
                    if (code[3])
                    begin
                        ps_next.line_err = 1'b1;
                    end
                    else
                    begin
                        ps_next.parsed = code[2:0];
                    end
                    ps_next.phase = PH_TXT_ARGS;
                end
                else
                begin
                    if (cur.arg_total < COUNT_W'(ARG_CAPACITY))
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = cur.arg_total[ARG_IDX_W-1:0];
                        ram_wdata         = cur.acc;
                        ps_next.arg_total = cur.arg_total + 1'b1;
                    end
                    else
                    begin
                        ps_next.line_err = 1'b1;
                    end
                    ps_next.acc = '0;
                end
            end

            if (eol)
            begin
                start_emit = 1'b1;
                if (ps_next.phase == PH_TXT_CMD || ps_next.line_err)
                begin
                    start_err = 1'b1;
                end
                else
                begin
                    start_code = ps_next.parsed;
                    start_n    = ps_next.arg_total;
                end
            end
        end

        if (start_emit)
        begin
            ps_next = '0;
        end
        if (start_err)
        begin
            start_code = CODE_ERROR;
            start_n    = '0;
        end

        if (!in_xfer)
        begin
            ps_next    = ps_reg;
            start_emit = 1'b0;
            ram_we     = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Emit sequencer: header, then arguments out of the RAM.
    // ---------------------------------------------------------------
    always_comb
    begin
        logic out_free;

        out_free        = !out_valid_reg || m_tready;
        seq_next        = seq_reg;
        em_code_next    = em_code_reg;
        em_n_next       = em_n_reg;
        em_err_next     = em_err_reg;
        em_idx_next     = em_idx_reg;
        out_load        = 1'b0;
        out_kind_next   = 1'b0;
        out_status_next = 1'b0;
        out_code_next   = em_code_reg;
        out_count_next  = em_n_reg;
        out_value_next  = '0;
        out_last_next   = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (seq_reg)
            SQ_PARSE:
            begin
                if (start_emit)
                begin
                    em_code_next = start_code;
                    em_n_next    = start_n;
                    em_err_next  = start_err;
                    seq_next     = SQ_HEAD;
                end
            end
            SQ_HEAD:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = em_err_reg;
                    out_last_next   = (em_n_reg == '0);
                    if (em_n_reg == '0)
                    begin
                        seq_next = SQ_PARSE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        em_idx_next = '0;
                        seq_next    = SQ_ARG;
                    end
                end
            end
            SQ_ARG:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = 1'b1;
                    out_value_next = ram_rdata;
                    out_last_next  = (COUNT_W'(em_idx_reg) + 1'b1 == em_n_reg);
                    if (out_last_next)
                    begin
                        seq_next = SQ_PARSE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = em_idx_reg + 1'b1;
                        em_idx_next = em_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                seq_next = SQ_PARSE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
            ps_reg          <= '0;
            seq_reg         <= SQ_PARSE;
            em_code_reg     <= '0;
            em_n_reg        <= '0;
            em_err_reg      <= 1'b0;
            em_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                binary_mode_reg <= cfg_wdata;
                ps_reg          <= '0;
            end
            else
            begin
                ps_reg <= ps_next;
            end
            seq_reg       <= seq_next;
            em_code_reg   <= em_code_next;
            em_n_reg      <= em_n_next;
            em_err_reg    <= em_err_next;
            em_idx_reg    <= em_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_code_reg   <= out_code_next;
            out_count_reg  <= out_count_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg, out_count_reg, out_code_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/core/sclp_ram.sv */
`timescale 1ns / 1ps
module sclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sclp_checker.sv */
`timescale 1ns / 1ps
`include "serial_command_line_parser_core_defines.svh"
module sclp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    `SCLP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // an error header stands alone with code and count cleared
    `SCLP_ASSERT_NOW(a_err_hdr, m_tvalid && !m_tuser && m_tdata[0], m_tlast && m_tdata[7:1] == 7'd0)

    // arguments never carry an error
    `SCLP_ASSERT_NOW(a_arg_ok, m_tvalid && m_tuser, !m_tdata[0] && m_tdata[7:4] != 4'd0)

    // a header is last exactly when no arguments follow
    `SCLP_ASSERT_NOW(a_hdr_last, m_tvalid && !m_tuser, m_tlast == (m_tdata[7:4] == 4'd0))

endmodule

bind serial_command_line_parser_core sclp_checker u_sclp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
